### hw/rtl/dpid_pkg.sv
package dpid_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int ERROR_W  = SAMPLE_W + 1;
	localparam int COEF_W   = 24;
	localparam int LIMIT_W  = 15;
	localparam int DRIVE_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;

	// Coefficient fraction bits (Q8.16)
	localparam int FRAC_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A2     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = 3'd5;

	// Register reset values
	localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_B1_RST = 24'sd0;
	localparam logic signed [COEF_W-1:0] COEF_B2_RST = 24'sd0;
	localparam logic signed [COEF_W-1:0] COEF_A1_RST = 24'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_A2_RST = 24'sd0;
	localparam logic [LIMIT_W-1:0]       LIMIT_RST   = 15'd32767;

	// Configuration set seen by the datapath
	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic [LIMIT_W-1:0]       limit;
	} coef_t;

	// Error and drive history
	typedef struct packed {
		logic signed [ERROR_W-1:0] e1;
		logic signed [ERROR_W-1:0] e2;
		logic signed [DRIVE_W-1:0] u1;
		logic signed [DRIVE_W-1:0] u2;
	} hist_t;

endpackage

### hw/rtl/dpid_calc.sv
// Difference equation: error, five products, floor shift, saturation, clamp.
module dpid_calc (
	input  logic signed [dpid_pkg::SAMPLE_W-1:0] setpoint,
	input  logic signed [dpid_pkg::SAMPLE_W-1:0] measurement,
	input  dpid_pkg::coef_t                      coef,
	input  dpid_pkg::hist_t                      hist,
	output logic signed [dpid_pkg::ERROR_W-1:0]  error,
	output logic signed [dpid_pkg::DRIVE_W-1:0]  drive,
	output logic signed [dpid_pkg::SAMPLE_W-1:0] drive_out
);

	localparam int PE_W  = dpid_pkg::COEF_W + dpid_pkg::ERROR_W;
	localparam int PU_W  = dpid_pkg::COEF_W + dpid_pkg::DRIVE_W;
	localparam int ACC_W = PU_W + 3;
	localparam int SH_W  = ACC_W - dpid_pkg::FRAC_W;
	localparam int DW    = dpid_pkg::DRIVE_W;

	logic signed [PE_W-1:0]  p_b0, p_b1, p_b2;
	logic signed [PU_W-1:0]  p_a1, p_a2;
	logic signed [ACC_W-1:0] acc;
	logic signed [SH_W-1:0]  sh;
	logic signed [DW-1:0]    lim_pos, lim_neg, res;
	logic                    ovf_pos, ovf_neg;

	// Error is exact in one extra bit
	assign error = dpid_pkg::ERROR_W'(setpoint) - dpid_pkg::ERROR_W'(measurement);

	// Exact products
	assign p_b0 = PE_W'(coef.b0) * PE_W'(error);
	assign p_b1 = PE_W'(coef.b1) * PE_W'(hist.e1);
	assign p_b2 = PE_W'(coef.b2) * PE_W'(hist.e2);
	assign p_a1 = PU_W'(coef.a1) * PU_W'(hist.u1);
	assign p_a2 = PU_W'(coef.a2) * PU_W'(hist.u2);

	assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
		+ ACC_W'(p_a1) + ACC_W'(p_a2);

	// Arithmetic shift rounds toward minus infinity
	assign sh = acc[ACC_W-1:dpid_pkg::FRAC_W];

	// Saturate to 32-bit signed: upper bits must all match the sign
	assign ovf_pos = !sh[SH_W-1] && (|sh[SH_W-2:DW-1]);
	assign ovf_neg = sh[SH_W-1] && !(&sh[SH_W-2:DW-1]);

	always_comb begin
		if (ovf_pos) begin
			drive = {1'b0, {(DW-1){1'b1}}};
		end else if (ovf_neg) begin
			drive = {1'b1, {(DW-1){1'b0}}};
		end else begin
			drive = sh[DW-1:0];
		end
	end

	// Magnitude clamp to the drive limit
	assign lim_pos = DW'(coef.limit);
	assign lim_neg = -lim_pos;

	always_comb begin
		if (drive > lim_pos) begin
			res = lim_pos;
		end else if (drive < lim_neg) begin
			res = lim_neg;
		end else begin
			res = drive;
		end
	end

	assign drive_out = res[dpid_pkg::SAMPLE_W-1:0];

endmodule

### hw/rtl/discrete_pid_controller.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   setpoint, measurement
// output    out_valid / out_stall drive_out
// config    cfg_we                cfg_index, cfg_data
//
// One result per sample, one sample per cycle sustained while the output is not stalled;
// a sample passes the input register, then the result register. The difference
// equation and the history update sit between the two registers, so each sample
// sees the history the previous one left.
// arst_n clears valids and history and loads the coefficient reset values.
// A stalled result holds; the input register fills behind it, then in_stall rises.
module discrete_pid_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [dpid_pkg::SAMPLE_W-1:0] setpoint,
	input  logic signed [dpid_pkg::SAMPLE_W-1:0] measurement,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [dpid_pkg::SAMPLE_W-1:0] drive_out,
	input  logic                                 cfg_we,
	input  logic [dpid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpid_pkg::CFG_DATA_W-1:0]      cfg_data
);

	dpid_pkg::coef_t coef_q;
	dpid_pkg::hist_t hist_q;

	logic                                 valid_s1;
	logic signed [dpid_pkg::SAMPLE_W-1:0] setpoint_s1, measurement_s1;
	logic                                 out_valid_q;
	logic signed [dpid_pkg::SAMPLE_W-1:0] drive_out_q;

	logic signed [dpid_pkg::ERROR_W-1:0]  error;
	logic signed [dpid_pkg::DRIVE_W-1:0]  drive;
	logic signed [dpid_pkg::SAMPLE_W-1:0] drive_clamped;
	logic                                 out_free, advance, in_xfer;

	// Pipeline control
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_xfer  = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0    <= dpid_pkg::COEF_B0_RST;
			coef_q.b1    <= dpid_pkg::COEF_B1_RST;
			coef_q.b2    <= dpid_pkg::COEF_B2_RST;
			coef_q.a1    <= dpid_pkg::COEF_A1_RST;
			coef_q.a2    <= dpid_pkg::COEF_A2_RST;
			coef_q.limit <= dpid_pkg::LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dpid_pkg::CFG_COEF_B0:     coef_q.b0 <= cfg_data;
				dpid_pkg::CFG_COEF_B1:     coef_q.b1 <= cfg_data;
				dpid_pkg::CFG_COEF_B2:     coef_q.b2 <= cfg_data;
				dpid_pkg::CFG_COEF_A1:     coef_q.a1 <= cfg_data;
				dpid_pkg::CFG_COEF_A2:     coef_q.a2 <= cfg_data;
				dpid_pkg::CFG_DRIVE_LIMIT: coef_q.limit <= cfg_data[dpid_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			setpoint_s1    <= setpoint;
			measurement_s1 <= measurement;
		end
	end

	dpid_calc u_calc (
		.setpoint    (setpoint_s1),
		.measurement (measurement_s1),
		.coef        (coef_q),
		.hist        (hist_q),
		.error       (error),
		.drive       (drive),
		.drive_out   (drive_clamped)
	);

	// History update as the sample moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			hist_q.e2 <= hist_q.e1;
			hist_q.e1 <= error;
			hist_q.u2 <= hist_q.u1;
			hist_q.u1 <= drive;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_out_q <= drive_clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_out = drive_out_q;

endmodule

### tb/tb_discrete_pid_controller.sv
`timescale 1ns / 100ps

module tb_discrete_pid_controller;
	import dpid_pkg::*;

	// Register slots the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

	localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;
	localparam logic [COEF_W-1:0] COEF_MAX = 24'h7FFFFF;
	localparam logic [COEF_W-1:0] COEF_ONE = 24'h010000;

	localparam longint DRIVE_MAX = 64'sd2147483647;
	localparam longint DRIVE_MIN = -64'sd2147483648;

	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int DIR_ROWS        = 32;

	typedef enum {PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH, PACE_HOLD} pace_e;
	typedef enum {GAINS_STABLE, GAINS_WILD, GAINS_EXTREME} gain_set_e;
	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

	typedef struct packed {
		row_kind_e                 kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
		logic signed [SAMPLE_W-1:0] sp;
		logic signed [SAMPLE_W-1:0] ms;
		logic                      has_drive;
		logic signed [SAMPLE_W-1:0] drive;
	} dir_row_t;

	// DUT ports
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] setpoint = '0;
	logic signed [SAMPLE_W-1:0] measurement = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] drive_out;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	// Predictor copy of registers and history
	logic signed [COEF_W-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
	logic [LIMIT_W-1:0]        drv_limit;
	logic signed [ERROR_W-1:0] err_hist1, err_hist2;
	logic signed [DRIVE_W-1:0] drv_hist1, drv_hist2;

	logic signed [SAMPLE_W-1:0] drive_expect_q[$];
	logic signed [SAMPLE_W-1:0] drive_want;
	int                         mismatches = 0;
	int                         cycle_count = 0;
	pace_e                      pace = PACE_FREE;
	int                         hold_left = 0;
	bit                         held_once = 1'b0;

	logic [COEF_W-1:0]  coef_corners [4] = '{COEF_MIN, COEF_MAX, '0, COEF_ONE};
	logic [LIMIT_W-1:0] limit_corners [3] = '{'0, 15'd1, LIMIT_RST};

	pace_e phase_pace [NUM_PHASES] = '{PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS,
		PACE_BOTH, PACE_HOLD, PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH};
	gain_set_e phase_gains [NUM_PHASES] = '{GAINS_STABLE, GAINS_STABLE, GAINS_WILD,
		GAINS_STABLE, GAINS_STABLE, GAINS_EXTREME, GAINS_STABLE, GAINS_EXTREME, GAINS_STABLE};

	// Directed rows; drive is typed in only where it follows by hand
	dir_row_t dir_table [DIR_ROWS] = '{
		// reset gains: pure integrator of the error
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b1, 16'sd32767},
		'{ROW_SAMPLE, CFG_SPARE7, '0, -16'sd32768, 16'sd32767, 1'b1, 16'sd0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, -16'sd32768, 16'sd32767, 1'b1, -16'sd32767},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd0, 16'sd0, 1'b1, -16'sd32767},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, 16'sd32767, 1'b1, -16'sd32767},
		// max gains drive the history into positive saturation
		'{ROW_WRITE, CFG_COEF_B0, COEF_MAX, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_COEF_A1, COEF_MAX, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, -16'sd32768, 16'sd32767, 1'b0, '0},
		// most negative feedback flips between both saturation rails
		'{ROW_WRITE, CFG_COEF_A1, COEF_MIN, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd0, 16'sd0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd0, 16'sd0, 1'b0, '0},
		// remaining extremes; zero limit with junk above the limit field
		'{ROW_WRITE, CFG_COEF_B1, COEF_MIN, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_COEF_B2, COEF_MAX, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_COEF_A2, COEF_MIN, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_COEF_A1, '0, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_DRIVE_LIMIT, 24'hFF8000, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, -16'sd32768, 1'b1, 16'sd0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, -16'sd32768, 16'sd32767, 1'b1, 16'sd0},
		// undecoded slots must not disturb anything; then full and unit drive limits
		'{ROW_WRITE, CFG_SPARE6, 24'hFFFFFF, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_SPARE7, 24'h123456, '0, '0, 1'b0, '0},
		'{ROW_WRITE, CFG_DRIVE_LIMIT, 24'hFFFFFF, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd1234, -16'sd4321, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, -16'sd32768, -16'sd32768, 1'b0, '0},
		'{ROW_WRITE, CFG_DRIVE_LIMIT, 24'h000001, '0, '0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd32767, 16'sd0, 1'b0, '0},
		'{ROW_SAMPLE, CFG_SPARE7, '0, 16'sd0, 16'sd32767, 1'b0, '0}
	};

	discrete_pid_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.setpoint    (setpoint),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_out   (drive_out),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic reset_pid();
		coef_b0   = COEF_B0_RST;
		coef_b1   = COEF_B1_RST;
		coef_b2   = COEF_B2_RST;
		coef_a1   = COEF_A1_RST;
		coef_a2   = COEF_A2_RST;
		drv_limit = LIMIT_RST;
		err_hist1 = '0;
		err_hist2 = '0;
		drv_hist1 = '0;
		drv_hist2 = '0;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_COEF_B0:     coef_b0 = data;
			CFG_COEF_B1:     coef_b1 = data;
			CFG_COEF_B2:     coef_b2 = data;
			CFG_COEF_A1:     coef_a1 = data;
			CFG_COEF_A2:     coef_a2 = data;
			CFG_DRIVE_LIMIT: drv_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	// Difference equation: exact sum, floor shift, 32-bit saturation, then clamp
	task automatic step_pid(input logic signed [SAMPLE_W-1:0] sp,
		input logic signed [SAMPLE_W-1:0] ms, output logic signed [SAMPLE_W-1:0] drive);
		logic signed [ERROR_W-1:0] err;
		longint acc;
		longint unclamped;
		longint lim;
		err = sp - ms;
		acc = longint'(coef_b0) * longint'(err) + longint'(coef_b1) * longint'(err_hist1)
			+ longint'(coef_b2) * longint'(err_hist2) + longint'(coef_a1) * longint'(drv_hist1)
			+ longint'(coef_a2) * longint'(drv_hist2);
		unclamped = acc >>> FRAC_W;
		if (unclamped > DRIVE_MAX)
			unclamped = DRIVE_MAX;
		if (unclamped < DRIVE_MIN)
			unclamped = DRIVE_MIN;
		err_hist2 = err_hist1;
		err_hist1 = err;
		drv_hist2 = drv_hist1;
		drv_hist1 = unclamped[DRIVE_W-1:0];
		lim = longint'(drv_limit);
		if (unclamped > lim)
			unclamped = lim;
		if (unclamped < -lim)
			unclamped = -lim;
		drive = unclamped[SAMPLE_W-1:0];
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		apply_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drain all results, then let the two-stage pipe empty out
	task automatic settle();
		in_valid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] sp,
		input logic signed [SAMPLE_W-1:0] ms, input logic has_drive,
		input logic signed [SAMPLE_W-1:0] typed_drive);
		logic signed [SAMPLE_W-1:0] predicted;
		int gap_pct;
		gap_pct = (pace == PACE_SEND_GAPS) ? 74 : (pace == PACE_BOTH) ? 14 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		setpoint    <= sp;
		measurement <= ms;
		do
			@(posedge clk);
		while (in_stall);
		step_pid(sp, ms, predicted);
		drive_expect_q.push_back(has_drive ? typed_drive : predicted);
	endtask

	// Mostly tracking samples near the setpoint, some raw noise and rail values
	task automatic random_sample();
		logic signed [SAMPLE_W-1:0] sp;
		logic signed [SAMPLE_W-1:0] ms;
		int pick;
		pick = $urandom_range(0, 99);
		sp = 16'($urandom);
		ms = 16'($urandom);
		if (pick < 5) begin
			sp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			ms = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		end else if (pick < 80) begin
			ms = sp + 16'(int'($urandom_range(0, 600)) - 300);
		end
		send_sample(sp, ms, 1'b0, '0);
	endtask

	task automatic load_gains(input gain_set_e kind);
		logic [COEF_W-1:0] b0, b1, b2, a1, a2;
		logic [LIMIT_W-1:0] lim;
		case (kind)
			GAINS_STABLE: begin
				// |a1| + |a2| stays below one so the loop settles
				b0 = 24'(int'($urandom_range(0, 262144)) - 131072);
				b1 = 24'(int'($urandom_range(0, 131072)) - 65536);
				b2 = 24'(int'($urandom_range(0, 131072)) - 65536);
				a1 = 24'($urandom_range(0, 45000));
				a2 = 24'(int'($urandom_range(0, 32000)) - 16000);
				lim = ($urandom_range(0, 3) == 0) ? LIMIT_RST : 15'($urandom_range(0, 32767));
			end
			GAINS_WILD: begin
				b0 = 24'($urandom);
				b1 = 24'($urandom);
				b2 = 24'($urandom);
				a1 = 24'($urandom);
				a2 = 24'($urandom);
				lim = 15'($urandom);
			end
			default: begin
				b0 = coef_corners[$urandom_range(0, 3)];
				b1 = coef_corners[$urandom_range(0, 3)];
				b2 = coef_corners[$urandom_range(0, 3)];
				a1 = coef_corners[$urandom_range(0, 3)];
				a2 = coef_corners[$urandom_range(0, 3)];
				lim = limit_corners[$urandom_range(0, 2)];
			end
		endcase
		cfg_write(CFG_COEF_B0, b0);
		cfg_write(CFG_COEF_B1, b1);
		cfg_write(CFG_COEF_B2, b2);
		cfg_write(CFG_COEF_A1, a1);
		cfg_write(CFG_COEF_A2, a2);
		// junk above the limit field must be dropped
		cfg_write(CFG_DRIVE_LIMIT, {9'($urandom), lim});
		if ($urandom_range(0, 1))
			cfg_write($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, 24'($urandom));
	endtask

	// Stimulus: directed table, then paced random phases
	initial begin
		reset_pid();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_table[r].kind == ROW_WRITE) begin
				settle();
				cfg_write(dir_table[r].idx, dir_table[r].data);
			end else begin
				send_sample(dir_table[r].sp, dir_table[r].ms, dir_table[r].has_drive,
					dir_table[r].drive);
			end
		end
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			pace <= phase_pace[p];
			load_gains(phase_gains[p]);
			repeat (ITEMS_PER_PHASE) random_sample();
		end
		settle();
		if (mismatches == 0 && drive_expect_q.size() == 0)
			$display("discrete_pid_controller verification clean");
		else
			$display("discrete_pid_controller verification failed");
		$finish;
	end

	// Receiver stall; hold pace starts long stretches so the input backs up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (pace == PACE_HOLD && (!held_once || $urandom_range(0, 299) == 0)) begin
			out_stall <= 1'b1;
			hold_left <= $urandom_range(150, 400);
			held_once <= 1'b1;
		end else if (pace == PACE_RECV_STALLS) begin
			out_stall <= ($urandom_range(0, 99) < 74);
		end else if (pace == PACE_BOTH) begin
			out_stall <= ($urandom_range(0, 99) < 14);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (drive_expect_q.size() == 0) begin
				$display("%0t: drive_out transfer, expected none, actual %0d",
					$time, drive_out);
				mismatches++;
			end else begin
				drive_want = drive_expect_q.pop_front();
				if (drive_out !== drive_want) begin
					$display("%0t: drive_out mismatch, expected %0d, actual %0d",
						$time, drive_want, drive_out);
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("discrete_pid_controller verification failed");
			$finish;
		end
	end

endmodule

### filelist.f
hw/rtl/dpid_pkg.sv
hw/rtl/dpid_calc.sv
hw/rtl/discrete_pid_controller.sv
tb/tb_discrete_pid_controller.sv
